FILE: rtl/prcxyz_pkg.sv
`default_nettype none
package prcxyz_pkg;

   // default sizes
   localparam int DEF_COORD_WIDTH    = 32;
   localparam int DEF_ANGLE_WIDTH    = 16;
   localparam int DEF_TRIG_FRAC_BITS = 15;

   // axis numbering, also the order of the rotations
   localparam int AXES   = 3;
   localparam int AXIS_X = 0;
   localparam int AXIS_Y = 1;
   localparam int AXIS_Z = 2;

   // number of nested steps in each trig series
   localparam int HORNER_STEPS = 6;

   // one flag per axis, x in the low bit
   typedef struct packed {
      logic z;
      logic y;
      logic x;
   } axis_flags_type;

   // series divisor as a reciprocal: n / k == (n * mul) >> shift for any n below 2^30
   typedef struct packed {
      logic [5:0]  shift;
      logic [30:0] mul;
   } recip_type;

   // sine series divisors 156, 110, 72, 42, 20, 6, innermost step first
   function automatic recip_type sin_recip(input logic [2:0] step);
      recip_type rc;
      case (step)
         3'd0: rc = {6'd38, 31'd1762037866};
         3'd1: rc = {6'd37, 31'd1249445032};
         3'd2: rc = {6'd37, 31'd1908874354};
         3'd3: rc = {6'd36, 31'd1636178018};
         3'd4: rc = {6'd35, 31'd1717986919};
         default: rc = {6'd33, 31'd1431655766};
      endcase
      return rc;
   endfunction

   // cosine series divisors 132, 90, 56, 30, 12, 2, innermost step first
   function automatic recip_type cos_recip(input logic [2:0] step);
      recip_type rc;
      case (step)
         3'd0: rc = {6'd38, 31'd2082408386};
         3'd1: rc = {6'd37, 31'd1527099484};
         3'd2: rc = {6'd36, 31'd1227133514};
         3'd3: rc = {6'd35, 31'd1145324613};
         3'd4: rc = {6'd34, 31'd1431655766};
         default: rc = {6'd31, 31'd1073741824};
      endcase
      return rc;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/prcxyz_trig.sv
`default_nettype none
module prcxyz_trig
   import prcxyz_pkg::*;
#(
   parameter int ANGLE_WIDTH    = DEF_ANGLE_WIDTH,
   parameter int TRIG_FRAC_BITS = DEF_TRIG_FRAC_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [ANGLE_WIDTH-1:0]           angle [AXES],
   input  axis_flags_type                   angle_wr,
   output logic                             busy,
   output logic signed [TRIG_FRAC_BITS+1:0] sin_val [AXES],
   output logic signed [TRIG_FRAC_BITS+1:0] cos_val [AXES]
);

   localparam int TW  = TRIG_FRAC_BITS + 2;
   localparam int QW  = 31;
   localparam int PRW = 61;

   localparam logic [QW-1:0] Q30_ONE     = 31'h4000_0000;
   localparam logic [QW-1:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [29:0]   HALF_QUAD   = 30'h2000_0000;
   localparam logic [QW-1:0] RND_Q       = QW'(1) << (29 - TRIG_FRAC_BITS);
   localparam logic signed [TW-1:0] TRIG_ONE = TW'(1) << TRIG_FRAC_BITS;
   localparam logic [2:0]    STEP_LAST   = 3'(HORNER_STEPS - 1);

   // sequencer states
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_MX   = 4'd1;
   localparam logic [3:0] ST_X    = 4'd2;
   localparam logic [3:0] ST_X2   = 4'd3;
   localparam logic [3:0] ST_MT   = 4'd4;
   localparam logic [3:0] ST_DL   = 4'd5;
   localparam logic [3:0] ST_DE   = 4'd6;
   localparam logic [3:0] ST_MS   = 4'd7;
   localparam logic [3:0] ST_ST   = 4'd8;

   // quadrant codes
   localparam logic [1:0] QUAD_I   = 2'd0;
   localparam logic [1:0] QUAD_II  = 2'd1;
   localparam logic [1:0] QUAD_III = 2'd2;

   logic [3:0]            state_ff, state_in;
   logic [AXES-1:0]       pend_ff, pend_in;
   logic [1:0]            sel_ff, sel_in;
   logic [1:0]            quad_ff, quad_in;
   logic                  swap_ff, swap_in;
   logic [29:0]           r_ff, r_in;
   logic [PRW-1:0]        prod_ff, prod_in;
   logic [29:0]           x_ff, x_in;
   logic [29:0]           x2_ff, x2_in;
   logic [QW-1:0]         ts_ff, ts_in;
   logic [QW-1:0]         tc_ff, tc_in;
   logic [2:0]            step_ff, step_in;
   logic                  cos_ph_ff, cos_ph_in;
   logic signed [TW-1:0]  sin_ff [AXES];
   logic signed [TW-1:0]  sin_in [AXES];
   logic signed [TW-1:0]  cos_ff [AXES];
   logic signed [TW-1:0]  cos_in [AXES];

   logic [AXES-1:0]       wr_vec;
   logic [AXES-1:0]       clr_vec;
   logic [1:0]            sel_pick;
   logic [31:0]           turn;
   logic                  swap_pick;
   logic [QW-1:0]         fold_diff;
   logic [29:0]           mul_a;
   logic [QW-1:0]         mul_b;
   recip_type             rcp_sel;
   logic [QW-1:0]         quot;
   logic [QW-1:0]         s_raw, s_use, c_use;
   logic [QW-1:0]         s_rnd, c_rnd;
   logic signed [TW-1:0]  sq, cq;

   assign wr_vec = angle_wr;
   assign busy   = (|pend_ff) || (state_ff != ST_IDLE);

   // lowest pending axis goes first
   always_comb begin
      if (pend_ff[AXIS_X]) begin
         sel_pick = 2'(AXIS_X);
      end else if (pend_ff[AXIS_Y]) begin
         sel_pick = 2'(AXIS_Y);
      end else begin
         sel_pick = 2'(AXIS_Z);
      end
   end

   // angle as a 32-bit turn, folded into half a quadrant
   assign turn      = 32'(angle[sel_pick]) << (32 - ANGLE_WIDTH);
   assign swap_pick = turn[29:0] > HALF_QUAD;
   assign fold_diff = Q30_ONE - {1'b0, turn[29:0]};

   // series divide as a multiply by the divisor's reciprocal, then a shift
   assign rcp_sel = cos_ph_ff ? cos_recip(step_ff) : sin_recip(step_ff);
   assign quot    = QW'(prod_ff >> rcp_sel.shift);

   // final values, swapped back and rounded to the trig format
   assign s_raw = prod_ff[60:30];
   assign s_use = swap_ff ? tc_ff : s_raw;
   assign c_use = swap_ff ? s_raw : tc_ff;
   assign s_rnd = s_use + RND_Q;
   assign c_rnd = c_use + RND_Q;
   assign sq    = {1'b0, s_rnd[QW-1 -: TRIG_FRAC_BITS+1]};
   assign cq    = {1'b0, c_rnd[QW-1 -: TRIG_FRAC_BITS+1]};

   // an axis leaves the pending set when its evaluation starts, a later write sets it again
   assign clr_vec = (state_ff == ST_IDLE) ? (AXES'(1) << sel_pick) : '0;

   // shared multiplier, product registered
   assign prod_in = mul_a * mul_b;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      pend_in   = (pend_ff & ~clr_vec) | wr_vec;
      sel_in    = sel_ff;
      quad_in   = quad_ff;
      swap_in   = swap_ff;
      r_in      = r_ff;
      x_in      = x_ff;
      x2_in     = x2_ff;
      ts_in     = ts_ff;
      tc_in     = tc_ff;
      step_in   = step_ff;
      cos_ph_in = cos_ph_ff;
      sin_in    = sin_ff;
      cos_in    = cos_ff;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (|pend_ff) begin
               sel_in   = sel_pick;
               quad_in  = turn[31:30];
               swap_in  = swap_pick;
               r_in     = swap_pick ? fold_diff[29:0] : turn[29:0];
               state_in = ST_MX;
            end
         end
         ST_MX: begin
            mul_a    = r_ff;
            mul_b    = HALF_PI_Q30;
            state_in = ST_X;
         end
         ST_X: begin
            x_in     = prod_ff[59:30];
            mul_a    = prod_ff[59:30];
            mul_b    = {1'b0, prod_ff[59:30]};
            state_in = ST_X2;
         end
         ST_X2: begin
            x2_in     = prod_ff[59:30];
            ts_in     = Q30_ONE;
            tc_in     = Q30_ONE;
            step_in   = '0;
            cos_ph_in = 1'b0;
            state_in  = ST_MT;
         end
         ST_MT: begin
            mul_a    = x2_ff;
            mul_b    = cos_ph_ff ? tc_ff : ts_ff;
            state_in = ST_DL;
         end
         ST_DL: begin
            mul_a    = prod_ff[59:30];
            mul_b    = rcp_sel.mul;
            state_in = ST_DE;
         end
         ST_DE: begin
            if (!cos_ph_ff) begin
               ts_in     = Q30_ONE - quot;
               cos_ph_in = 1'b1;
               state_in  = ST_MT;
            end else begin
               tc_in     = Q30_ONE - quot;
               cos_ph_in = 1'b0;
               if (step_ff == STEP_LAST) begin
                  state_in = ST_MS;
               end else begin
                  step_in  = step_ff + 3'd1;
                  state_in = ST_MT;
               end
            end
         end
         ST_MS: begin
            mul_a    = x_ff;
            mul_b    = ts_ff;
            state_in = ST_ST;
         end
         ST_ST: begin
            case (quad_ff)
               QUAD_I: begin
                  sin_in[sel_ff] = sq;
                  cos_in[sel_ff] = cq;
               end
               QUAD_II: begin
                  sin_in[sel_ff] = cq;
                  cos_in[sel_ff] = -sq;
               end
               QUAD_III: begin
                  sin_in[sel_ff] = -sq;
                  cos_in[sel_ff] = -cq;
               end
               default: begin
                  sin_in[sel_ff] = -cq;
                  cos_in[sel_ff] = sq;
               end
            endcase
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and trig results
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= '0;
         for (int a = 0; a < AXES; a++) begin
            sin_ff[a] <= '0;
            cos_ff[a] <= TRIG_ONE;
         end
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         sin_ff   <= sin_in;
         cos_ff   <= cos_in;
      end
   end

   // working values
   always_ff @(posedge clock) begin
      sel_ff    <= sel_in;
      quad_ff   <= quad_in;
      swap_ff   <= swap_in;
      r_ff      <= r_in;
      prod_ff   <= prod_in;
      x_ff      <= x_in;
      x2_ff     <= x2_in;
      ts_ff     <= ts_in;
      tc_ff     <= tc_in;
      step_ff   <= step_in;
      cos_ph_ff <= cos_ph_in;
   end

   assign sin_val = sin_ff;
   assign cos_val = cos_ff;

endmodule
`default_nettype wire

FILE: rtl/point_rotate_about_center_xyz_unit.sv
`default_nettype none
// Rotates one 3D point per request about a programmable center: the center is
// subtracted, the offset is rotated about X, then Y, then Z, the center is added
// back and each coordinate saturates to COORD_WIDTH signed bits (Q16.16 by
// default). The datapath is an 8-stage pipeline that takes a new point every
// clock while neither back-pressure nor a trig evaluation holds req_ready low;
// back-pressure on the result side stalls only the stages that are full.
// Registers sit at byte offset 4*i (8*i when COORD_WIDTH exceeds 32): center_x,
// center_y, center_z, angle_about_x, angle_about_y, angle_about_z, all reset to
// zero; angles are binary, 2^ANGLE_WIDTH units per turn. Every angle write starts
// a sine/cosine evaluation in a shared sequencer that holds req_ready low while
// it is pending or running; its single shared multiplier serves each of the
// twelve series terms, setup and rounding in turn; center writes take effect
// at once. Program the registers only while no request is in flight.
module point_rotate_about_center_xyz_unit
   import prcxyz_pkg::*;
#(
   parameter int COORD_WIDTH    = DEF_COORD_WIDTH,
   parameter int ANGLE_WIDTH    = DEF_ANGLE_WIDTH,
   parameter int TRIG_FRAC_BITS = DEF_TRIG_FRAC_BITS,
   localparam int CSR_DW = (COORD_WIDTH > 32) ? 64 : 32,
   localparam int CSR_AW = (COORD_WIDTH > 32) ? 6 : 5
) (
   input  logic                          clock,
   input  logic                          reset,
   // point requests
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_point_z,
   // rotated points
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_rotated_x,
   output logic signed [COORD_WIDTH-1:0] rsp_rotated_y,
   output logic signed [COORD_WIDTH-1:0] rsp_rotated_z,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_AW-1:0]             paddr,
   input  logic [CSR_DW-1:0]             pwdata,
   output logic [CSR_DW-1:0]             prdata,
   output logic                          pready
);

   localparam int V      = COORD_WIDTH + 4;
   localparam int TW     = TRIG_FRAC_BITS + 2;
   localparam int PW     = V + TW;
   localparam int SW     = PW + 1;
   localparam int OW     = V + 1;
   localparam int ROT_N  = 3;
   localparam int STAGES = 2 * ROT_N + 2;
   localparam int LAST   = STAGES - 1;
   localparam int IDX_LO = CSR_AW - 3;

   // product slots of one rotation
   localparam int P_AC = 0;
   localparam int P_BS = 1;
   localparam int P_AS = 2;
   localparam int P_BC = 3;
   localparam int P_N  = 4;

   // register indexes
   localparam logic [2:0] REG_CENTER_X = 3'd0;
   localparam logic [2:0] REG_CENTER_Y = 3'd1;
   localparam logic [2:0] REG_CENTER_Z = 3'd2;
   localparam logic [2:0] REG_ANGLE_X  = 3'd3;
   localparam logic [2:0] REG_ANGLE_Y  = 3'd4;
   localparam logic [2:0] REG_ANGLE_Z  = 3'd5;

   localparam logic signed [SW-1:0] RND    = SW'(1) << (TRIG_FRAC_BITS - 1);
   localparam logic signed [OW-1:0] SAT_HI = (OW'(1) << (COORD_WIDTH - 1)) - OW'(1);
   localparam logic signed [OW-1:0] SAT_LO = -(OW'(1) << (COORD_WIDTH - 1));

   logic [2:0]                    csr_idx;
   logic                          csr_wr;
   logic signed [COORD_WIDTH-1:0] center_ff [AXES];
   logic signed [COORD_WIDTH-1:0] center_in [AXES];
   logic [ANGLE_WIDTH-1:0]        angle_ff [AXES];
   logic [ANGLE_WIDTH-1:0]        angle_in [AXES];
   axis_flags_type                angle_wr;
   logic                          trig_busy;
   logic signed [TW-1:0]          sin_val [AXES];
   logic signed [TW-1:0]          cos_val [AXES];

   logic [STAGES-1:0]             vld_ff, vld_in, en;
   logic                          accept;
   logic signed [COORD_WIDTH-1:0] pt [AXES];
   logic signed [V-1:0]           crd_ff [ROT_N+1][AXES];
   logic signed [V-1:0]           crd_in [ROT_N+1][AXES];
   logic signed [PW-1:0]          prd_ff [ROT_N][P_N];
   logic signed [PW-1:0]          prd_in [ROT_N][P_N];
   logic signed [V-1:0]           pas_ff [ROT_N];
   logic signed [V-1:0]           pas_in [ROT_N];
   logic signed [COORD_WIDTH-1:0] res_ff [AXES];
   logic signed [COORD_WIDTH-1:0] res_in [AXES];

   // register port decode
   assign pready  = 1'b1;
   assign csr_idx = paddr[CSR_AW-1:IDX_LO];
   assign csr_wr  = psel & penable & pwrite & pready;

   always_comb begin
      center_in = center_ff;
      angle_in  = angle_ff;
      angle_wr  = '0;
      if (csr_wr) begin
         case (csr_idx)
            REG_CENTER_X: center_in[AXIS_X] = pwdata[COORD_WIDTH-1:0];
            REG_CENTER_Y: center_in[AXIS_Y] = pwdata[COORD_WIDTH-1:0];
            REG_CENTER_Z: center_in[AXIS_Z] = pwdata[COORD_WIDTH-1:0];
            REG_ANGLE_X: begin
               angle_in[AXIS_X] = pwdata[ANGLE_WIDTH-1:0];
               angle_wr.x       = 1'b1;
            end
            REG_ANGLE_Y: begin
               angle_in[AXIS_Y] = pwdata[ANGLE_WIDTH-1:0];
               angle_wr.y       = 1'b1;
            end
            REG_ANGLE_Z: begin
               angle_in[AXIS_Z] = pwdata[ANGLE_WIDTH-1:0];
               angle_wr.z       = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            center_ff[a] <= '0;
            angle_ff[a]  <= '0;
         end
      end else begin
         center_ff <= center_in;
         angle_ff  <= angle_in;
      end
   end

   // register readback
   always_comb begin
      case (csr_idx)
         REG_CENTER_X: prdata = CSR_DW'(center_ff[AXIS_X]);
         REG_CENTER_Y: prdata = CSR_DW'(center_ff[AXIS_Y]);
         REG_CENTER_Z: prdata = CSR_DW'(center_ff[AXIS_Z]);
         REG_ANGLE_X:  prdata = CSR_DW'(angle_ff[AXIS_X]);
         REG_ANGLE_Y:  prdata = CSR_DW'(angle_ff[AXIS_Y]);
         REG_ANGLE_Z:  prdata = CSR_DW'(angle_ff[AXIS_Z]);
         default:      prdata = '0;
      endcase
   end

   // sine and cosine per axis
   prcxyz_trig #(
      .ANGLE_WIDTH    (ANGLE_WIDTH),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_trig (
      .clock    (clock),
      .reset    (reset),
      .angle    (angle_ff),
      .angle_wr (angle_wr),
      .busy     (trig_busy),
      .sin_val  (sin_val),
      .cos_val  (cos_val)
   );

   // per-stage load enables, a stage moves when empty or when the next one moves
   always_comb begin
      en[LAST] = !vld_ff[LAST] || rsp_ready;
      for (int k = LAST - 1; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign req_ready = en[0] && !trig_busy;
   assign accept    = req_valid && req_ready;

   always_comb begin
      vld_in[0] = en[0] ? accept : vld_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // offset from the center
   assign pt[AXIS_X] = req_point_x;
   assign pt[AXIS_Y] = req_point_y;
   assign pt[AXIS_Z] = req_point_z;

   for (genvar a = 0; a < AXES; a++) begin : g_diff
      assign crd_in[0][a] = V'(pt[a]) - V'(center_ff[a]);
   end

   // one rotation: a' = a*c - b*s, b' = a*s + b*c, the third axis passes through
   for (genvar r = 0; r < ROT_N; r++) begin : g_rot
      localparam int IA = (r == AXIS_X) ? AXIS_Y : (r == AXIS_Y) ? AXIS_Z : AXIS_X;
      localparam int IB = (r == AXIS_X) ? AXIS_Z : (r == AXIS_Y) ? AXIS_X : AXIS_Y;
      logic signed [SW-1:0] sum_a;
      logic signed [SW-1:0] sum_b;

      assign prd_in[r][P_AC] = crd_ff[r][IA] * cos_val[r];
      assign prd_in[r][P_BS] = crd_ff[r][IB] * sin_val[r];
      assign prd_in[r][P_AS] = crd_ff[r][IA] * sin_val[r];
      assign prd_in[r][P_BC] = crd_ff[r][IB] * cos_val[r];
      assign pas_in[r]       = crd_ff[r][r];

      // exact sums, rounded once
      assign sum_a = SW'(prd_ff[r][P_AC]) - SW'(prd_ff[r][P_BS]) + RND;
      assign sum_b = SW'(prd_ff[r][P_AS]) + SW'(prd_ff[r][P_BC]) + RND;

      assign crd_in[r+1][IA] = sum_a[TRIG_FRAC_BITS +: V];
      assign crd_in[r+1][IB] = sum_b[TRIG_FRAC_BITS +: V];
      assign crd_in[r+1][r]  = pas_ff[r];
   end

   // center added back, saturated
   for (genvar a = 0; a < AXES; a++) begin : g_out
      logic signed [OW-1:0] tot;
      assign tot = OW'(crd_ff[ROT_N][a]) + OW'(center_ff[a]);
      assign res_in[a] = (tot > SAT_HI) ? COORD_WIDTH'(SAT_HI) :
                         (tot < SAT_LO) ? COORD_WIDTH'(SAT_LO) :
                         tot[COORD_WIDTH-1:0];
   end

   // pipeline payload registers
   always_ff @(posedge clock) begin
      for (int r = 0; r <= ROT_N; r++) begin
         if (en[2*r]) begin
            crd_ff[r] <= crd_in[r];
         end
      end
      for (int r = 0; r < ROT_N; r++) begin
         if (en[2*r+1]) begin
            prd_ff[r] <= prd_in[r];
            pas_ff[r] <= pas_in[r];
         end
      end
      if (en[LAST]) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid     = vld_ff[LAST];
   assign rsp_rotated_x = res_ff[AXIS_X];
   assign rsp_rotated_y = res_ff[AXIS_Y];
   assign rsp_rotated_z = res_ff[AXIS_Z];

`ifndef NO_ASSERTIONS
   // an accepted request occupies the first stage next cycle
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> vld_ff[0])
      else $error("accepted request did not enter the pipeline");

   // the stage in front of the output hands its item over when it moves
   a_handover: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[LAST-1] && en[LAST-1]) |=> rsp_valid)
      else $error("item lost between last stage and output");

   // a full pipeline with a stalled output takes no request
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      ((&vld_ff) && !rsp_ready) |-> !req_ready)
      else $error("request taken while pipeline full and stalled");

   // reset leaves the pipeline empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (vld_ff == '0))
      else $error("pipeline not empty after reset");
`endif

endmodule
`default_nettype wire
